// ----- rtl/core/kfq_pkg.sv -----
// shared types and constants for the keyed fifo queue
package kfq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_UPDATE = 2'd3
  } kfq_action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } kfq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DEQ
  } kfq_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fin_search;
    logic fin_deq;
  } kfq_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } kfq_sts_t;

endpackage

// ----- rtl/core/keyed_fifo_queue.sv -----
// top level of the keyed fifo queue
// A first-in first-out queue of unique key and value pairs held in a ring of
// DEPTH entries. A command is taken when start is high and busy is low; one
// result follows, shown for a single cycle with out_valid high, and the
// receiver cannot stall it. A dequeue passes through the S_DEQ state before
// the next transfer. Enqueue, lookup and update search the queued keys
// from the front, one entry per cycle through the read port of the key ram;
// the search ends on a hit or once every queued entry has been read. The
// result appears in the first cycle with busy low, and a new command may be
// transferred in that same cycle.
module keyed_fifo_queue
  import kfq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic signed [DATA_W-1:0]          in_key,
  input  logic signed [DATA_W-1:0]          in_value,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic signed [DATA_W-1:0]          out_key,
  output logic signed [DATA_W-1:0]          out_value,
  output logic [$clog2(DEPTH+1)-1:0]        out_occupancy,
  output logic                              out_is_empty
);

  kfq_cmd_t cmd;
  kfq_sts_t sts;

  kfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  kfq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_value      (in_value),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_value     (out_value),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty)
  );

`ifndef SYNTH
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a command in flight");

  a_transfer_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("occupancy above depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_key == '0) && (out_value == '0)))
    else $error("nonzero payload on a failed command");
`endif

endmodule

// ----- rtl/core/kfq_ram.sv -----
// generic single write port ram with registered read
module kfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/kfq_ctrl.sv -----
// controller state machine for the keyed fifo queue
module kfq_ctrl
  import kfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_action,
  input  kfq_sts_t   sts,
  output kfq_cmd_t   cmd,
  output logic       busy
);

  kfq_state_t  state_r;
  kfq_state_t  state_nxt;
  kfq_action_t act;

  assign act = kfq_action_t'(in_action);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (act)
            ACT_DEQ: state_nxt = S_DEQ;
            default: state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.exhausted) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEQ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.fin_search = sts.hit || sts.exhausted;
      end
      S_DEQ: cmd.fin_deq = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

// ----- rtl/core/kfq_dp.sv -----
// datapath: ring pointers, key scan and result registers
module kfq_dp
  import kfq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kfq_cmd_t                   cmd,
  input  logic [1:0]                 in_action,
  input  logic [DATA_W-1:0]          in_key,
  input  logic [DATA_W-1:0]          in_value,
  output kfq_sts_t                   sts,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [DATA_W-1:0]          out_key,
  output logic [DATA_W-1:0]          out_value,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy,
  output logic                       out_is_empty
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [IDX_W-1:0]  pipe_slot_r, pipe_slot_nxt;
  logic              pipe_vld_r, pipe_vld_nxt;
  kfq_action_t       action_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] value_r;

  logic              out_valid_r, out_valid_nxt;
  kfq_status_t       status_r, status_nxt;
  logic [DATA_W-1:0] okey_r, okey_nxt;
  logic [DATA_W-1:0] oval_r, oval_nxt;
  logic [CNT_W-1:0]  occ_r;
  logic              empty_r;

  logic [DATA_W-1:0] key_rdata;
  logic [DATA_W-1:0] val_rdata;
  logic [IDX_W-1:0]  rd_addr;
  logic              key_we;
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W:0]    tail_sum;
  logic              issue;

  kfq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (tail),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  kfq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  assign rd_addr = cmd.scan ? slot_r : head_r;
  assign issue   = idx_r < count_r;

  assign sts.hit       = pipe_vld_r && (key_rdata == key_r);
  assign sts.exhausted = !pipe_vld_r && !issue;

  always_comb begin
    tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    if (tail_sum >= (CNT_W+1)'(DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  // scan bookkeeping
  always_comb begin
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    pipe_vld_nxt  = pipe_vld_r;
    pipe_slot_nxt = pipe_slot_r;
    if (cmd.load) begin
      idx_nxt      = '0;
      slot_nxt     = head_r;
      pipe_vld_nxt = 1'b0;
    end else if (cmd.scan) begin
      pipe_vld_nxt  = issue;
      pipe_slot_nxt = slot_r;
      if (issue) begin
        idx_nxt  = idx_r + CNT_W'(1);
        slot_nxt = (slot_r == IDX_W'(DEPTH - 1)) ? '0 : slot_r + IDX_W'(1);
      end
    end
  end

  // result and state update
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    status_nxt    = ST_OK;
    okey_nxt      = '0;
    oval_nxt      = '0;
    key_we        = 1'b0;
    val_we        = 1'b0;
    val_waddr     = tail;
    out_valid_nxt = cmd.fin_search || cmd.fin_deq;
    if (cmd.fin_deq) begin
      if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        okey_nxt  = key_rdata;
        oval_nxt  = val_rdata;
        head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (cmd.fin_search) begin
      case (action_r)
        ACT_ENQ: begin
          if (sts.hit) begin
            status_nxt = ST_DUP;
          end else if (count_r == CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_LOOKUP: begin
          if (sts.hit) begin
            okey_nxt = key_rdata;
            oval_nxt = val_rdata;
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        ACT_UPDATE: begin
          if (sts.hit) begin
            val_we    = 1'b1;
            val_waddr = pipe_slot_r;
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        default: status_nxt = ST_MISSING;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    pipe_slot_r <= pipe_slot_nxt;
    if (cmd.load) begin
      action_r <= kfq_action_t'(in_action);
      key_r    <= in_key;
      value_r  <= in_value;
    end
    if (out_valid_nxt) begin
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      oval_r   <= oval_nxt;
      occ_r    <= count_nxt;
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_key       = okey_r;
  assign out_value     = oval_r;
  assign out_occupancy = occ_r;
  assign out_is_empty  = empty_r;

endmodule
